/* rtl/assert_macros.svh */
// Assertion macros for the jitter buffer.
// Included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m: check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m: check failed");
`endif

/* rtl/rtpjb_pkg.sv */
// Types and constants for the RTP jitter buffer.
// No dependencies.
`default_nettype none
package rtpjb_pkg;
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_GAP     = 3'd1;
  localparam logic [2:0] ST_LENERR  = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_DELIVER = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;
  localparam logic [10:0] HDR_LEN = 11'd12;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [0:0] OP_WRITE = 1'b0;
  localparam logic [0:0] OP_READ = 1'b1;
  localparam logic [0:0] REG_MAXLEN = 1'b0;
  localparam logic [0:0] REG_WAIT = 1'b1;

  typedef struct packed {
    logic [0:0]  op;
    logic [15:0] seq_number;
    logic [10:0] packet_len;
    logic [31:0] now_ms;
    logic [0:0]  ext_flag;
    logic [4:0]  nal_type;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] out_slot;
    logic [10:0] out_len;
    logic [0:0]  need_keyframe;
    logic [15:0] loss_resets;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
  } sts_t;
endpackage
`default_nettype wire

/* rtl/rtp_jitter_buffer_reorder.sv */
// channel | payload      | handshake
// in      | in_item_t    | in_valid / in_stall
// out     | out_item_t   | out_valid / out_stall
// An item passes through capture, memory read, update and present; present holds while out_stall is high.
// The slot memory has one port; reading and writing take separate cycles.
// After reset a clearing pass marks every slot empty; no item is taken meanwhile.
// A timeout runs the same pass once its result is taken.
// Top level of the RTP jitter buffer; depends on rtpjb_pkg, rtpjb_ctrl, rtpjb_dp.
`default_nettype none
`include "assert_macros.svh"
module rtp_jitter_buffer_reorder #(
  parameter int SLOT_COUNT = 2048,
  parameter int LEN_BITS = 11
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire rtpjb_pkg::in_item_t in_item,
  output logic out_valid,
  input  wire logic out_stall,
  output rtpjb_pkg::out_item_t out_item,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  rtpjb_pkg::cmd_t cmd;
  rtpjb_pkg::sts_t sts;
  logic [10:0] max_len;
  logic [15:0] wait_limit;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= 11'd1400;
      wait_limit <= 16'd100;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2:2] == rtpjb_pkg::REG_MAXLEN) max_len <= pwdata[10:0];
      else wait_limit <= pwdata[15:0];
    end
  end
  always_comb begin
    if (paddr[2:2] == rtpjb_pkg::REG_MAXLEN) prdata = {21'd0, max_len};
    else prdata = {16'd0, wait_limit};
  end

  rtpjb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  rtpjb_dp #(.SLOT_COUNT(SLOT_COUNT), .LEN_BITS(LEN_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_item(in_item),
    .max_len(max_len), .wait_limit(wait_limit), .out_item(out_item)
  );

  `CHK_IMPL(a_no_in_while_out, clk, rst, out_valid, in_stall)
  `CHK_NEXT(a_out_after_update, clk, rst, cmd.update, out_valid)
  `CHK_IMPL(a_status_range, clk, rst, out_valid, out_item.status <= rtpjb_pkg::ST_TIMEOUT)
endmodule
`default_nettype wire

/* rtl/rtpjb_ctrl.sv */
// Controller state machine for the jitter buffer.
// Depends on rtpjb_pkg.
`default_nettype none
module rtpjb_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire logic out_stall,
  input  wire rtpjb_pkg::sts_t sts,
  output rtpjb_pkg::cmd_t cmd
);
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_UPD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = sts.clear_done ? S_IDLE : S_CLEAR;
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/rtpjb_dp.sv */
// Datapath for the jitter buffer: slot memory, valid marks, pointers, gap tracking.
// Depends on rtpjb_pkg.
`default_nettype none
module rtpjb_dp #(
  parameter int SLOT_COUNT = 2048,
  parameter int LEN_BITS = 11
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire rtpjb_pkg::cmd_t cmd,
  output rtpjb_pkg::sts_t sts,
  input  wire rtpjb_pkg::in_item_t in_item,
  input  wire logic [10:0] max_len,
  input  wire logic [15:0] wait_limit,
  output rtpjb_pkg::out_item_t out_item
);
  localparam int AW = $clog2(SLOT_COUNT);
  // entry: valid bit, length, arrival
  localparam int EW = 1 + LEN_BITS + 32;

  logic [EW-1:0] mem [SLOT_COUNT];
  logic [AW:0] clr_cnt;
  rtpjb_pkg::in_item_t it;
  logic [EW-1:0] rd;
  logic [AW-1:0] addr;
  logic [15:0] target;

  logic have_written, read_started, keyframe_wanted;
  logic [15:0] newest_seq, last_read_seq, gap_first, gap_last, gap_remaining, reset_count;
  logic [31:0] last_read_time;

  logic len_bad;
  logic [15:0] diff, off, span;
  logic rd_hit;
  logic timeout_hit;
  logic [31:0] elapsed;

  assign len_bad = (it.packet_len <= rtpjb_pkg::HDR_LEN) || (it.packet_len > max_len);
  assign target = read_started ? last_read_seq + 16'd1 : last_read_seq;
  assign addr = (it.op == rtpjb_pkg::OP_WRITE) ? it.seq_number[AW-1:0] : target[AW-1:0];
  assign diff = it.seq_number - newest_seq;
  assign off = it.seq_number - gap_first;
  assign span = gap_last - gap_first;
  assign rd_hit = rd[EW-1];
  assign elapsed = it.now_ms - last_read_time;
  assign timeout_hit = (it.op == rtpjb_pkg::OP_READ) && have_written && !rd_hit &&
                       (elapsed > {16'd0, wait_limit});
  assign sts.clear_done = clr_cnt[AW];

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.update && timeout_hit) clr_cnt <= '0;
    else if (cmd.clear_step && !clr_cnt[AW]) clr_cnt <= clr_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step && !clr_cnt[AW]) mem[clr_cnt[AW-1:0]] <= '0;
    else if (cmd.update && it.op == rtpjb_pkg::OP_WRITE && !len_bad)
      mem[addr] <= {1'b1, LEN_BITS'(it.packet_len), it.now_ms};
    else if (cmd.update && it.op == rtpjb_pkg::OP_READ && have_written && rd_hit)
      mem[addr] <= {1'b0, rd[EW-2:0]};
    if (cmd.lookup) rd <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) it <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_written <= 1'b0;
      read_started <= 1'b0;
      keyframe_wanted <= 1'b0;
      newest_seq <= '0;
      last_read_seq <= '0;
      gap_first <= '0;
      gap_last <= '0;
      gap_remaining <= '0;
      reset_count <= '0;
      last_read_time <= '0;
      out_item <= '0;
    end else if (cmd.update) begin
      out_item.out_slot <= '0;
      out_item.out_len <= '0;
      out_item.need_keyframe <= keyframe_wanted;
      out_item.loss_resets <= reset_count;
      if (it.op == rtpjb_pkg::OP_WRITE) begin
        if (len_bad) out_item.status <= rtpjb_pkg::ST_LENERR;
        else begin
          out_item.status <= rtpjb_pkg::ST_OK;
          if (keyframe_wanted && it.ext_flag[0] && it.nal_type == rtpjb_pkg::NAL_SPS) begin
            keyframe_wanted <= 1'b0;
            out_item.need_keyframe <= 1'b0;
          end
          if (!have_written) begin
            have_written <= 1'b1;
            newest_seq <= it.seq_number;
            last_read_seq <= it.seq_number;
          end else if (diff != 16'd0 && !diff[15]) begin
            if (diff > 16'd1) begin
              gap_first <= newest_seq + 16'd1;
              gap_last <= it.seq_number - 16'd1;
              gap_remaining <= diff - 16'd1;
              out_item.status <= rtpjb_pkg::ST_GAP;
            end
            newest_seq <= it.seq_number;
          end else if (diff[15]) begin
            if (gap_remaining != 16'd0 && off <= span) gap_remaining <= gap_remaining - 16'd1;
          end
        end
      end else begin
        if (!have_written) out_item.status <= rtpjb_pkg::ST_NONE;
        else begin
          read_started <= 1'b1;
          if (rd_hit) begin
            last_read_seq <= target;
            last_read_time <= rd[31:0];
            out_item.status <= rtpjb_pkg::ST_DELIVER;
            out_item.out_slot <= 11'(addr);
            out_item.out_len <= 11'(rd[EW-2:32]);
          end else if (!timeout_hit) begin
            out_item.status <= rtpjb_pkg::ST_NONE;
          end else begin
            have_written <= 1'b0;
            newest_seq <= '0;
            read_started <= 1'b0;
            last_read_seq <= '0;
            last_read_time <= '0;
            keyframe_wanted <= 1'b1;
            out_item.need_keyframe <= 1'b1;
            if (reset_count != 16'hFFFF) begin
              reset_count <= reset_count + 16'd1;
              out_item.loss_resets <= reset_count + 16'd1;
            end
            out_item.status <= rtpjb_pkg::ST_TIMEOUT;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* bench/tb_rtp_jitter_buffer_reorder.sv */
// Self-checking testbench for the RTP jitter buffer: writes and reads of packet
// descriptors, checked against a behavioural predictor. Depends on rtpjb_pkg and the top level.
`timescale 1ns / 1ps
module tb_rtp_jitter_buffer_reorder;
  localparam int SLOTS = 2048;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  rtpjb_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rtpjb_pkg::out_item_t out_item;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rtp_jitter_buffer_reorder dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [10:0] max_len;
  logic [15:0] wait_ms;
  logic        ready_map [SLOTS];
  logic [10:0] len_map [SLOTS];
  logic [31:0] arrival_map [SLOTS];
  logic        written, reading, kf_wanted;
  logic [15:0] newest, last_seq, gfirst, glast, gleft, resets;
  logic [31:0] last_time;

  rtpjb_pkg::out_item_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int accepted = 0;
  int n_deliver = 0, n_timeout = 0, n_gap = 0;
  bit idle_en = 1'b0;
  logic [31:0] clock_ms = 0;
  logic [15:0] next_seq = 0;

  function automatic rtpjb_pkg::out_item_t predict_step(rtpjb_pkg::in_item_t it);
    rtpjb_pkg::out_item_t r;
    logic [15:0] d, tgt;
    logic [10:0] s;
    r = '0;
    if (it.op == rtpjb_pkg::OP_WRITE) begin
      r.status = rtpjb_pkg::ST_OK;
      if (it.packet_len <= rtpjb_pkg::HDR_LEN || it.packet_len > max_len) begin
        r.status = rtpjb_pkg::ST_LENERR;
      end else begin
        if (kf_wanted && it.ext_flag == 1'b1 && it.nal_type == rtpjb_pkg::NAL_SPS)
          kf_wanted = 1'b0;
        s = it.seq_number[10:0];
        ready_map[s] = 1'b1;
        len_map[s] = it.packet_len;
        arrival_map[s] = it.now_ms;
        if (!written) begin
          written = 1'b1;
          newest = it.seq_number;
          last_seq = it.seq_number;
        end else begin
          d = it.seq_number - newest;
          if (d == 0) begin
          end else if (d < 16'h8000) begin
            if (d > 1) begin
              gfirst = newest + 16'd1;
              glast = it.seq_number - 16'd1;
              gleft = d - 16'd1;
              r.status = rtpjb_pkg::ST_GAP;
            end
            newest = it.seq_number;
          end else if (gleft != 0 &&
                       16'(it.seq_number - gfirst) <= 16'(glast - gfirst)) begin
            gleft = gleft - 16'd1;
          end
        end
      end
    end else if (!written) begin
      r.status = rtpjb_pkg::ST_NONE;
    end else begin
      if (reading) tgt = last_seq + 16'd1;
      else begin
        tgt = last_seq;
        reading = 1'b1;
      end
      s = tgt[10:0];
      if (ready_map[s]) begin
        ready_map[s] = 1'b0;
        last_seq = tgt;
        last_time = arrival_map[s];
        r.status = rtpjb_pkg::ST_DELIVER;
        r.out_slot = s;
        r.out_len = len_map[s];
      end else if (32'(it.now_ms - last_time) <= {16'd0, wait_ms}) begin
        r.status = rtpjb_pkg::ST_NONE;
      end else begin
        foreach (ready_map[i]) ready_map[i] = 1'b0;
        written = 1'b0;
        newest = '0;
        reading = 1'b0;
        last_seq = '0;
        last_time = '0;
        kf_wanted = 1'b1;
        if (resets != 16'hFFFF) resets = resets + 16'd1;
        r.status = rtpjb_pkg::ST_TIMEOUT;
      end
    end
    r.need_keyframe = kf_wanted;
    r.loss_resets = resets;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d items outstanding", $time, expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) out_stall <= idle_en && ($urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    rtpjb_pkg::out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected item %p", $time, out_item);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.status == rtpjb_pkg::ST_DELIVER) n_deliver++;
        if (e.status == rtpjb_pkg::ST_TIMEOUT) n_timeout++;
        if (e.status == rtpjb_pkg::ST_GAP) n_gap++;
        if (out_item.status !== e.status || out_item.out_slot !== e.out_slot ||
            out_item.out_len !== e.out_len || out_item.need_keyframe !== e.need_keyframe ||
            out_item.loss_resets !== e.loss_resets) begin
          $display("%0t mismatch: expected %p actual %p", $time, e, out_item);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input rtpjb_pkg::in_item_t it);
    while (idle_en && $urandom_range(99) < 17) @(posedge clk);
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_step(it));
    accepted++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_pkt(input logic [15:0] sq, input logic [10:0] ln,
                           input logic [31:0] t, input logic ex, input logic [4:0] nal);
    rtpjb_pkg::in_item_t it;
    it = '{op: rtpjb_pkg::OP_WRITE, seq_number: sq, packet_len: ln, now_ms: t,
           ext_flag: ex, nal_type: nal};
    send_item(it);
  endtask

  task automatic read_pkt(input logic [31:0] t);
    rtpjb_pkg::in_item_t it;
    it = '{op: rtpjb_pkg::OP_READ, seq_number: 16'($urandom), packet_len: 11'($urandom),
           now_ms: t, ext_flag: 1'($urandom), nal_type: 5'($urandom)};
    send_item(it);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    logic [31:0] exp_rd;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == rtpjb_pkg::REG_MAXLEN) begin
      max_len = val[10:0];
      exp_rd = {21'd0, val[10:0]};
    end else begin
      wait_ms = val[15:0];
      exp_rd = {16'd0, val[15:0]};
    end
    #1;
    if (prdata !== exp_rd) begin
      $display("%0t register readback: expected %h actual %h", $time, exp_rd, prdata);
      errors++;
    end
  endtask

  task automatic test_directed();
    write_reg(rtpjb_pkg::REG_MAXLEN, 32'd2047);
    write_reg(rtpjb_pkg::REG_WAIT, 32'd0);
    read_pkt(32'd0);
    write_pkt(16'd100, 11'd12, 32'd5, 1'b0, 5'd0);
    write_pkt(16'd100, 11'd0, 32'd5, 1'b1, 5'd31);
    write_pkt(16'd100, 11'd13, 32'd10, 1'b0, 5'd7);
    write_pkt(16'd101, 11'd2047, 32'd11, 1'b1, 5'd1);
    write_pkt(16'd101, 11'd500, 32'd12, 1'b0, 5'd0);
    write_pkt(16'd105, 11'd600, 32'd13, 1'b0, 5'd0);
    write_pkt(16'd103, 11'd700, 32'd14, 1'b0, 5'd0);
    write_pkt(16'd90, 11'd700, 32'd14, 1'b0, 5'd0);
    read_pkt(32'd20);
    read_pkt(32'd20);
    read_pkt(32'd20);
    read_pkt(32'hFFFF_FFFF);
    write_pkt(16'd0, 11'd40, 32'd1, 1'b1, 5'd6);
    write_pkt(16'd1, 11'd40, 32'd1, 1'b0, 5'd7);
    write_pkt(16'd2, 11'd40, 32'd1, 1'b1, 5'd7);
    write_pkt(16'hFFFF, 11'd40, 32'd2, 1'b0, 5'd0);
    write_pkt(16'd32770, 11'd40, 32'd3, 1'b0, 5'd0);
    read_pkt(32'd1);
    read_pkt(32'd1);
    read_pkt(32'd1);
    read_pkt(32'd2);
    drain();
  endtask

  task automatic test_limits();
    write_reg(rtpjb_pkg::REG_MAXLEN, 32'd13);
    write_reg(rtpjb_pkg::REG_WAIT, 32'd65535);
    write_pkt(16'd7, 11'd14, 32'd0, 1'b0, 5'd0);
    write_pkt(16'd7, 11'd13, 32'd0, 1'b0, 5'd0);
    read_pkt(32'd0);
    read_pkt(32'd65535);
    read_pkt(32'd65536);
    drain();
  endtask

  // runs of mostly in-order writes with reorder, loss and reads mixed in
  task automatic test_random(input int count);
    int k;
    logic [15:0] sq;
    logic [10:0] ln;
    for (k = 0; k < count; k++) begin
      idle_en = !(k >= count / 3 && k < count / 2);
      clock_ms = clock_ms + $urandom_range(20);
      if ($urandom_range(99) < 40) begin
        read_pkt($urandom_range(99) < 5 ? 32'($urandom) : clock_ms);
      end else begin
        case ($urandom_range(9))
          0: sq = 16'($urandom);
          1: sq = next_seq - 16'($urandom_range(8));
          2: sq = next_seq + 16'($urandom_range(6));
          default: sq = next_seq;
        endcase
        if (sq - next_seq < 16'h8000) next_seq = sq + 16'd1;
        ln = ($urandom_range(19) == 0) ? 11'($urandom) : 11'($urandom_range(1400, 13));
        write_pkt(sq, ln, clock_ms - $urandom_range(3), 1'($urandom),
                  ($urandom_range(3) == 0) ? rtpjb_pkg::NAL_SPS : 5'($urandom));
      end
    end
    idle_en = 1'b1;
    drain();
  endtask

  initial begin
    max_len = 11'd1400;
    wait_ms = 16'd100;
    foreach (ready_map[i]) begin
      ready_map[i] = 1'b0;
      len_map[i] = '0;
      arrival_map[i] = '0;
    end
    written = 0; reading = 0; kf_wanted = 0;
    newest = 0; last_seq = 0; gfirst = 0; glast = 0; gleft = 0; resets = 0;
    last_time = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limits();
    idle_en = 1'b1;
    write_reg(rtpjb_pkg::REG_MAXLEN, 32'd1400);
    write_reg(rtpjb_pkg::REG_WAIT, 32'd100);
    test_random(700);
    write_reg(rtpjb_pkg::REG_MAXLEN, 32'd2047);
    write_reg(rtpjb_pkg::REG_WAIT, 32'd30);
    test_random(650);
    $display("%0d items sent; %0d delivered, %0d gaps, %0d timeout clears",
             accepted, n_deliver, n_gap, n_timeout);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
